@@ hw/rtl/polygon_winding_number_defines.svh @@
// Assertion macros used by the polygon winding number RTL.
`ifndef POLYGON_WINDING_NUMBER_DEFINES_SVH
`define POLYGON_WINDING_NUMBER_DEFINES_SVH

// A condition that must hold at every clock edge outside reset.
`define PWN_ASSERT(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error("polygon_winding_number: assertion failed");

// An implication checked at every clock edge outside reset.
`define PWN_ASSERT_IMP(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("polygon_winding_number: implication failed");

`endif

@@ hw/rtl/pwn_pkg.sv @@
// Types, command codes and helpers for the polygon winding number block.
`timescale 1ns / 1ps

package pwn_pkg;

  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_QUERY  = 2'd2
  } pwn_cmd_e;

  localparam int WC_W   = 8;
  localparam int WC_MAX = 127;
  localparam int WC_MIN = -128;

  // Control bits that travel with a query item along the cell chain.
  // up and down qualify the edge whose products travel with the item.
  typedef struct packed {
    logic valid;
    logic up;
    logic down;
  } pwn_tok_t;

  // Per-cell view of the vertex count.
  typedef struct packed {
    logic en;    // this cell holds a vertex of the polygon
    logic wrap;  // last vertex and the cells beyond it: the edge closes to vertex 0
  } pwn_seg_t;

  // Winding step of one edge from the crossing class and the cross-product sign.
  function automatic logic signed [1:0] edge_inc(input logic up, input logic down,
                                                 input logic neg, input logic nz);
    logic signed [1:0] r;
    r = 2'sd0;
    if (up && neg) begin
      r = 2'sd1;
    end else if (down && nz && !neg) begin
      r = $signed(2'b11);
    end
    return r;
  endfunction

endpackage

@@ hw/rtl/pwn_cell.sv @@
// One vertex cell: stores a vertex, forms the cross products of its edge and
// resolves the products of the edge handed over by the previous cell.
`timescale 1ns / 1ps

module pwn_cell import pwn_pkg::*; #(
  parameter int CW   = 20,
  parameter int ACCW = 8
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   wr_en_i,
  input  logic signed [CW-1:0]   wr_x_i,
  input  logic signed [CW-1:0]   wr_y_i,
  input  pwn_seg_t               seg_i,
  output logic signed [CW-1:0]   vtx_x_o,
  output logic signed [CW-1:0]   vtx_y_o,
  input  logic signed [CW-1:0]   nxt_x_i,
  input  logic signed [CW-1:0]   nxt_y_i,
  input  logic signed [CW-1:0]   first_x_i,
  input  logic signed [CW-1:0]   first_y_i,
  input  pwn_tok_t               ctl_i,
  input  logic signed [CW-1:0]   px_i,
  input  logic signed [CW-1:0]   py_i,
  input  logic signed [2*CW+1:0] p1_i,
  input  logic signed [2*CW+1:0] p2_i,
  input  logic signed [ACCW-1:0] acc_i,
  output pwn_tok_t               ctl_o,
  output logic signed [CW-1:0]   px_o,
  output logic signed [CW-1:0]   py_o,
  output logic signed [2*CW+1:0] p1_o,
  output logic signed [2*CW+1:0] p2_o,
  output logic signed [ACCW-1:0] acc_o
);

  localparam int DW = CW + 1;
  localparam int PW = 2 * DW;
  localparam int SW = PW + 1;

  logic signed [CW-1:0]   vx_q, vy_q;
  logic signed [CW-1:0]   bx, by;
  logic signed [DW-1:0]   dpx, dpy, dbx, dby;
  logic signed [SW-1:0]   diff;
  logic signed [PW-1:0]   p1_d, p2_d, p1_q, p2_q;
  logic signed [ACCW-1:0] acc_d, acc_q;
  logic signed [CW-1:0]   px_q, py_q;
  pwn_tok_t               ctl_d, ctl_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      vx_q <= wr_x_i;
      vy_q <= wr_y_i;
    end
  end

  assign vtx_x_o = vx_q;
  assign vtx_y_o = vy_q;

  always_comb begin
    bx  = seg_i.wrap ? first_x_i : nxt_x_i;
    by  = seg_i.wrap ? first_y_i : nxt_y_i;
    dpx = DW'(px_i) - DW'(vx_q);
    dpy = DW'(py_i) - DW'(vy_q);
    dbx = DW'(bx) - DW'(vx_q);
    dby = DW'(by) - DW'(vy_q);
    p1_d = PW'(dpx) * PW'(dby);
    p2_d = PW'(dpy) * PW'(dbx);

    ctl_d.valid = ctl_i.valid;
    ctl_d.up    = seg_i.en && (vy_q <= py_i) && (by > py_i);
    ctl_d.down  = seg_i.en && (vy_q > py_i) && (by <= py_i);

    // Finish the edge of the previous cell while this edge is multiplied.
    diff  = SW'(p1_i) - SW'(p2_i);
    acc_d = acc_i + ACCW'(edge_inc(ctl_i.up, ctl_i.down, diff[SW-1], |diff));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= ctl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    px_q  <= px_i;
    py_q  <= py_i;
    p1_q  <= p1_d;
    p2_q  <= p2_d;
    acc_q <= acc_d;
  end

  assign ctl_o = ctl_q;
  assign px_o  = px_q;
  assign py_o  = py_q;
  assign p1_o  = p1_q;
  assign p2_o  = p2_q;
  assign acc_o = acc_q;

endmodule

@@ hw/rtl/polygon_winding_number.sv @@
// Top level of the polygon winding number block: command decode, vertex
// count, the chain of vertex cells and the result register.
//
// Clear and append commands complete when accepted and leave busy low. A
// query item walks the chain of MAX_VERTICES vertex cells, one cell per
// cycle, and is then captured in the result register; busy is high from
// the accepting edge until the item leaves the last cell, whatever the
// vertex count. The result is shown on the result ports for exactly one
// cycle with result_valid_o and cannot be held off, so capture it when it
// comes. Appends beyond MAX_VERTICES vertices are dropped and reported
// through overflowed_o until the next clear; command code 3 is ignored.
`timescale 1ns / 1ps
`include "polygon_winding_number_defines.svh"

module polygon_winding_number import pwn_pkg::*; #(
  parameter int MAX_VERTICES = 64,
  parameter int COORD_WIDTH  = 20
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    command_i,
  input  logic signed [COORD_WIDTH-1:0] x_coord_i,
  input  logic signed [COORD_WIDTH-1:0] y_coord_i,
  output logic                          result_valid_o,
  output logic signed [WC_W-1:0]        winding_count_o,
  output logic                          inside_res_o,
  output logic                          overflowed_o
);

  localparam int CW   = COORD_WIDTH;
  localparam int CNTW = $clog2(MAX_VERTICES + 1);
  localparam int ACCW = CNTW + 1;
  localparam int PW   = 2 * (CW + 1);
  localparam int SW   = PW + 1;
  localparam int NT   = MAX_VERTICES + 1;

  logic [CNTW-1:0] count_q, count_d;
  logic            drop_q, drop_d;
  logic            busy_q, busy_d;
  logic            accept, app_ok;

  logic signed [CW-1:0]   vx    [MAX_VERTICES];
  logic signed [CW-1:0]   vy    [MAX_VERTICES];
  logic signed [CW-1:0]   nxt_x [MAX_VERTICES];
  logic signed [CW-1:0]   nxt_y [MAX_VERTICES];
  pwn_tok_t               t_ctl [NT];
  logic signed [CW-1:0]   t_px  [NT];
  logic signed [CW-1:0]   t_py  [NT];
  logic signed [PW-1:0]   t_p1  [NT];
  logic signed [PW-1:0]   t_p2  [NT];
  logic signed [ACCW-1:0] t_acc [NT];
  logic [NT-1:0]          tok_valid;

  logic signed [SW-1:0]   fin_diff;
  logic signed [ACCW:0]   fin_acc;
  int                     fin_int;
  logic signed [WC_W-1:0] wc_d, wc_q;
  logic                   res_valid_q, inside_q, ovf_q;

  assign accept = start && !busy_q;
  assign app_ok = accept && (command_i == CMD_APPEND) && (count_q < CNTW'(MAX_VERTICES));

  always_comb begin
    count_d = count_q;
    drop_d  = drop_q;
    busy_d  = busy_q;
    if (accept) begin
      if (command_i == CMD_CLEAR) begin
        count_d = '0;
        drop_d  = 1'b0;
      end else if (command_i == CMD_APPEND) begin
        if (app_ok) begin
          count_d = count_q + CNTW'(1);
        end else begin
          drop_d = 1'b1;
        end
      end else if (command_i == CMD_QUERY) begin
        busy_d = 1'b1;
      end
    end
    // The item leaving the last cell is registered as the result now.
    if (t_ctl[MAX_VERTICES].valid) begin
      busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      drop_q  <= 1'b0;
      busy_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      drop_q  <= drop_d;
      busy_q  <= busy_d;
    end
  end

  assign busy = busy_q;

  // A fresh query enters the chain with nothing pending and a zero count.
  assign t_ctl[0].valid = accept && (command_i == CMD_QUERY);
  assign t_ctl[0].up    = 1'b0;
  assign t_ctl[0].down  = 1'b0;
  assign t_px[0]        = x_coord_i;
  assign t_py[0]        = y_coord_i;
  assign t_p1[0]        = '0;
  assign t_p2[0]        = '0;
  assign t_acc[0]       = '0;

  for (genvar i = 0; i < MAX_VERTICES; i++) begin : g_cell
    pwn_seg_t seg;
    logic     wr_en;

    assign seg.en   = CNTW'(i) < count_q;
    assign seg.wrap = CNTW'(i + 1) >= count_q;
    assign wr_en    = app_ok && (count_q == CNTW'(i));

    if (i < MAX_VERTICES - 1) begin : g_mid
      assign nxt_x[i] = vx[i+1];
      assign nxt_y[i] = vy[i+1];
    end else begin : g_last
      assign nxt_x[i] = vx[0];
      assign nxt_y[i] = vy[0];
    end

    pwn_cell #(
      .CW   (CW),
      .ACCW (ACCW)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .wr_en_i   (wr_en),
      .wr_x_i    (x_coord_i),
      .wr_y_i    (y_coord_i),
      .seg_i     (seg),
      .vtx_x_o   (vx[i]),
      .vtx_y_o   (vy[i]),
      .nxt_x_i   (nxt_x[i]),
      .nxt_y_i   (nxt_y[i]),
      .first_x_i (vx[0]),
      .first_y_i (vy[0]),
      .ctl_i     (t_ctl[i]),
      .px_i      (t_px[i]),
      .py_i      (t_py[i]),
      .p1_i      (t_p1[i]),
      .p2_i      (t_p2[i]),
      .acc_i     (t_acc[i]),
      .ctl_o     (t_ctl[i+1]),
      .px_o      (t_px[i+1]),
      .py_o      (t_py[i+1]),
      .p1_o      (t_p1[i+1]),
      .p2_o      (t_p2[i+1]),
      .acc_o     (t_acc[i+1])
    );
  end

  for (genvar k = 0; k < NT; k++) begin : g_tv
    assign tok_valid[k] = t_ctl[k].valid;
  end

  // Resolve the last edge and saturate to the result width.
  always_comb begin
    fin_diff = SW'(t_p1[MAX_VERTICES]) - SW'(t_p2[MAX_VERTICES]);
    fin_acc  = (ACCW + 1)'(t_acc[MAX_VERTICES])
             + (ACCW + 1)'(edge_inc(t_ctl[MAX_VERTICES].up, t_ctl[MAX_VERTICES].down,
                                    fin_diff[SW-1], |fin_diff));
    fin_int  = int'(fin_acc);
    if (fin_int > WC_MAX) begin
      wc_d = WC_W'(WC_MAX);
    end else if (fin_int < WC_MIN) begin
      wc_d = WC_W'(WC_MIN);
    end else begin
      wc_d = WC_W'(fin_int);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= t_ctl[MAX_VERTICES].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    wc_q     <= wc_d;
    inside_q <= (wc_d != '0);
    ovf_q    <= drop_q;
  end

  assign result_valid_o  = res_valid_q;
  assign winding_count_o = wc_q;
  assign inside_res_o    = inside_q;
  assign overflowed_o    = ovf_q;

  `PWN_ASSERT(a_count_in_range, count_q <= CNTW'(MAX_VERTICES))
  `PWN_ASSERT(a_single_item_in_chain, $onehot0(tok_valid))
  `PWN_ASSERT_IMP(a_result_needs_busy, res_valid_q, $past(busy_q))
  `PWN_ASSERT_IMP(a_chain_item_while_busy, |tok_valid[NT-1:1], busy_q)

endmodule
